@@ src/psf_pkg.sv @@
// ============================================================================
// psf_pkg
// Shared types and constants for the planar span fill block.
// ============================================================================
package psf_pkg;

    localparam int MAX_GROUPS = 20;
    localparam int GW         = 5;
    localparam int ADDR_W     = 22;
    localparam int BASE_W     = 21;
    localparam int Q_DEPTH    = 2;

    localparam logic REG_SCREEN_BASE = 1'b0;

    typedef struct packed {
        logic [ADDR_W-1:0] row_addr;
        logic [3:0]        x_lo;
        logic [3:0]        last_lo;
        logic [GW-1:0]     g_first;
        logic [GW-1:0]     g_last;
        logic [3:0]        color;
        logic              fin;
    } t_span;

endpackage

@@ src/psf_front.sv @@
// ============================================================================
// psf_front
// Classifies an incoming span: drops empty, off-screen or clipped-out ones,
// clips at row end and computes row address and first/last word group.
// ============================================================================
module psf_front
    import psf_pkg::*;
#(
    parameter int ROW_WORDS   = 80,
    parameter int SCREEN_ROWS = 200
) (
    input  logic [7:0]        i_row,
    input  logic [8:0]        i_x_start,
    input  logic [8:0]        i_width,
    input  logic [3:0]        i_color,
    input  logic              i_final_row,
    input  logic [BASE_W-1:0] i_screen_base,
    output logic              o_keep,
    output t_span             o_span
);

    localparam int RAW_GROUPS = ROW_WORDS / 4;
    localparam int GROUPS     = (RAW_GROUPS > MAX_GROUPS) ? MAX_GROUPS : RAW_GROUPS;
    localparam logic [9:0] ROW_PIX = 10'(GROUPS * 16);

    logic [9:0]  w_sum;
    logic [9:0]  w_end;
    logic [9:0]  w_end_m1;
    logic [15:0] w_prod;

    always_comb begin
        w_sum    = 10'(i_x_start) + 10'(i_width);
        w_end    = (w_sum > ROW_PIX) ? ROW_PIX : w_sum;
        w_end_m1 = w_end - 10'd1;
        w_prod   = 16'(ROW_WORDS) * 16'(i_row);

        o_keep = (32'(i_row) < SCREEN_ROWS) && (i_width != 9'd0)
                 && (10'(i_x_start) < ROW_PIX);

        o_span.row_addr = ADDR_W'(i_screen_base) + ADDR_W'(w_prod);
        o_span.x_lo     = i_x_start[3:0];
        o_span.last_lo  = w_end_m1[3:0];
        o_span.g_first  = i_x_start[8:4];
        o_span.g_last   = w_end_m1[8:4];
        o_span.color    = i_color;
        o_span.fin      = i_final_row;
    end

endmodule

@@ src/psf_queue.sv @@
// ============================================================================
// psf_queue
// Short span queue between classifier and write generator.
// ============================================================================
module psf_queue
    import psf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_span i_span,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_vld,
    output t_span o_span
);

    localparam int PW = $clog2(Q_DEPTH);

    t_span             r_mem [Q_DEPTH];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [PW:0]       r_cnt;
    logic [PW-1:0]     n_wp;
    logic [PW-1:0]     n_rp;
    logic [PW:0]       n_cnt;

    assign o_full = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_span = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (32'(r_wp) == Q_DEPTH - 1) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (32'(r_rp) == Q_DEPTH - 1) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (PW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_span;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(Q_DEPTH))
        else $error("span queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full span queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_vld)
        else $error("pop from empty span queue");

endmodule

@@ src/psf_back.sv @@
// ============================================================================
// psf_back
// Walks the word groups of one span, one masked write per cycle.
// ============================================================================
module psf_back
    import psf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_vld,
    input  t_span             i_span,
    output logic              o_pop,
    output logic              o_strobe,
    output logic [ADDR_W-1:0] o_word_address,
    output logic [15:0]       o_write_mask,
    output logic [15:0]       o_plane0_word,
    output logic [15:0]       o_plane1_word,
    output logic [15:0]       o_plane2_word,
    output logic [15:0]       o_plane3_word,
    output logic              o_row_end,
    output logic              o_rect_end
);

    logic          r_active;
    t_span         r_span;
    logic [GW-1:0] r_g;
    logic          w_last;
    logic [3:0]    w_lo;
    logic [4:0]    w_hi;
    logic          r_strobe;

    assign w_last = (r_g == r_span.g_last);
    assign o_pop  = i_q_vld && (!r_active || w_last);
    assign w_lo   = (r_g == r_span.g_first) ? r_span.x_lo : 4'd0;
    assign w_hi   = w_last ? (5'(r_span.last_lo) + 5'd1) : 5'd16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (r_active && !w_last) begin
                r_g <= r_g + GW'(1);
            end else if (i_q_vld) begin
                r_active <= 1'b1;
                r_span   <= i_span;
                r_g      <= i_span.g_first;
            end else begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_word_address <= r_span.row_addr + ADDR_W'({r_g, 2'b00});
        o_write_mask   <= (16'hFFFF >> w_lo) & ~(16'hFFFF >> w_hi);
        o_plane0_word  <= {16{r_span.color[0]}};
        o_plane1_word  <= {16{r_span.color[1]}};
        o_plane2_word  <= {16{r_span.color[2]}};
        o_plane3_word  <= {16{r_span.color[3]}};
        o_row_end      <= w_last;
        o_rect_end     <= w_last && r_span.fin;
    end

    assign o_strobe = r_strobe;

    a_rect_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rect_end |-> o_row_end)
        else $error("rect end without row end");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_active))
        else $error("write without active span");

    a_group_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_g <= r_span.g_last)
        else $error("group walk passed last group");

endmodule

@@ src/planar_span_fill.sv @@
// ============================================================================
// planar_span_fill
// Row span fill for a 4-bitplane word-interleaved screen: one masked
// write per 16-pixel group touched by the span.
// ============================================================================
//  channel   | handshake                        | payload
//  ----------+----------------------------------+------------------------------
//  span in   | start / busy                     | i_row i_x_start i_width ...
//  write out | o_strobe (one cycle, no stall)   | o_word_address o_write_mask..
//  config    | psel penable pwrite pready       | paddr pwdata prdata
//
//  A span of N groups yields N writes, one per cycle; the first reaches the ports
//  through the span queue, the group walker and the output registers. The group walker
//  sets the rate, and a queued span starts the cycle after the previous one's last group.
//  Empty, clipped-out or off-screen spans produce no transaction.
//  busy is high while the span queue is full.
//  Synchronous active-low reset empties the queue and clears screen_base.
// ============================================================================
module planar_span_fill
    import psf_pkg::*;
#(
    parameter int ROW_WORDS   = 80,
    parameter int SCREEN_ROWS = 200
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [7:0]        i_row,
    input  logic [8:0]        i_x_start,
    input  logic [8:0]        i_width,
    input  logic [3:0]        i_color,
    input  logic              i_final_row,
    output logic              o_strobe,
    output logic [ADDR_W-1:0] o_word_address,
    output logic [15:0]       o_write_mask,
    output logic [15:0]       o_plane0_word,
    output logic [15:0]       o_plane1_word,
    output logic [15:0]       o_plane2_word,
    output logic [15:0]       o_plane3_word,
    output logic              o_row_end,
    output logic              o_rect_end,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [BASE_W-1:0] r_screen_base;
    logic              w_keep;
    t_span             w_span;
    logic              w_full;
    logic              w_q_vld;
    t_span             w_q_span;
    logic              w_pop;
    logic              w_accept;

    assign pready   = 1'b1;
    assign busy     = w_full;
    assign w_accept = start && !w_full;
    assign prdata   = (paddr[2] == REG_SCREEN_BASE) ? 32'(r_screen_base) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_base <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SCREEN_BASE)) begin
            r_screen_base <= pwdata[BASE_W-1:0];
        end
    end

    psf_front #(
        .ROW_WORDS   (ROW_WORDS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_front (
        .i_row         (i_row),
        .i_x_start     (i_x_start),
        .i_width       (i_width),
        .i_color       (i_color),
        .i_final_row   (i_final_row),
        .i_screen_base (r_screen_base),
        .o_keep        (w_keep),
        .o_span        (w_span)
    );

    psf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept && w_keep),
        .i_span  (w_span),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_vld   (w_q_vld),
        .o_span  (w_q_span)
    );

    psf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_vld        (w_q_vld),
        .i_span         (w_q_span),
        .o_pop          (w_pop),
        .o_strobe       (o_strobe),
        .o_word_address (o_word_address),
        .o_write_mask   (o_write_mask),
        .o_plane0_word  (o_plane0_word),
        .o_plane1_word  (o_plane1_word),
        .o_plane2_word  (o_plane2_word),
        .o_plane3_word  (o_plane3_word),
        .o_row_end      (o_row_end),
        .o_rect_end     (o_rect_end)
    );

endmodule
